>>> rtl/ght_pkg.sv
// Shared types and constants for the generational handle table.
// Holds the action codes, field widths and the memory entry layouts.
// No dependencies.
package ght_pkg;

	localparam int ADDR_W   = 64;
	localparam int KIND_W   = 8;
	localparam int HANDLE_W = 64;
	localparam int ID_W     = 40;
	localparam int GEN_W    = 16;
	localparam int ACT_W    = 3;
	localparam int IN_RAW_W = ACT_W + ADDR_W + KIND_W + HANDLE_W;
	localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_REGISTER   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INV_ADDR   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INV_HANDLE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RESOLVE    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd4;

	localparam logic [GEN_W-1:0] GEN_MAX = 16'hFFFF;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
	} live_ent_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [KIND_W-1:0] kind;
		logic [GEN_W-1:0]  last;
	} gen_ent_t;

endpackage

>>> rtl/ght_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for both tables of the handle table. No dependencies.
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/generational_handle_table.sv
// Top level of the generational handle table: sequencer, scans and result register.
// Depends on ght_pkg and ght_ram.
//
// Channel  Dir  Fields (low bit first)
// s_*      in   action[2:0], obj_address[66:3], obj_kind[74:67], handle_in[138:75]
// m_*      out  handle_out[63:0], ok[64], address_out[128:65], kind_out[136:129],
//               live_count[137 +: $clog2(TABLE_DEPTH+1)]
//
// A transaction scans the whole live table. A valid register of a pair that is not
// live, while a live slot is free, also runs the generation scan after it.
// Each scan reads one entry per cycle from its RAM.
// Reset empties both tables through valid flip-flops at once, with no clearing pass.
// A new input is taken in the idle state even while a result waits on m_tready;
// the block stalls before loading the output register until that result is taken.
module generational_handle_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int GEN_DEPTH   = 256,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int OUT_W = ((64 + 1 + 64 + 8 + CNT_W + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// action, obj_address, obj_kind, handle_in
	input  logic [ght_pkg::IN_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// handle_out, ok, address_out, kind_out, live_count
	output logic [OUT_W-1:0]         m_tdata
);
	import ght_pkg::*;

	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int GW = $clog2(GEN_DEPTH);

	typedef enum logic [2:0] {ST_IDLE, ST_LSCAN, ST_LDEC, ST_GSCAN, ST_GDEC, ST_DONE} state_t;

	state_t state_q;
	logic [ACT_W-1:0]    act_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [KIND_W-1:0]   kind_q;
	logic [HANDLE_W-1:0] hin_q;

	logic [TW-1:0] lsc_q, lidx_s1, hit_idx_q, free_idx_q;
	logic [GW-1:0] gsc_q, gidx_s1, ghit_idx_q, gfree_idx_q;
	logic iss_done_q, rd_vld_s1, rd_last_s1;
	logic hit_q, free_q, ghit_q, gfree_q;
	live_ent_t hit_ent_q;
	logic [GEN_W-1:0] glast_q;

	logic [TABLE_DEPTH-1:0] live_vld_q;
	logic [GEN_DEPTH-1:0]   gen_vld_q;
	logic [ID_W-1:0]        next_id_q;
	logic [CNT_W-1:0]       total_q;

	logic [HANDLE_W-1:0] res_h_q, o_h_q;
	logic [ADDR_W-1:0]   res_a_q, o_a_q;
	logic [KIND_W-1:0]   res_k_q, o_k_q;
	logic                res_ok_q, o_ok_q, m_tvalid_q;
	logic [CNT_W-1:0]    o_cnt_q;

	live_ent_t live_rd, live_wr;
	gen_ent_t  gen_rd, gen_wr;
	logic live_we, gen_we, issue, last_issue, key_hit, gen_key_hit, slot_ok;
	logic [GW-1:0]    gslot;
	logic [GEN_W-1:0] new_gen;

	// The FSM keeps reads (scan states) and writes (decide states) apart, so no
	// entry is read while a write to it is pending.
	assign issue      = (state_q == ST_LSCAN || state_q == ST_GSCAN) && !iss_done_q;
	assign last_issue = (state_q == ST_LSCAN) ? (lsc_q == TW'(TABLE_DEPTH - 1))
		: (gsc_q == GW'(GEN_DEPTH - 1));

	assign key_hit = (act_q == ACT_REGISTER || act_q == ACT_INV_ADDR)
		? (live_rd.addr == addr_q && live_rd.kind == kind_q)
		: (live_rd.handle == hin_q);
	assign gen_key_hit = gen_rd.addr == addr_q && gen_rd.kind == kind_q;

	assign slot_ok = (ghit_q || gfree_q) && next_id_q != '0;
	assign gslot   = ghit_q ? ghit_idx_q : gfree_idx_q;
	assign new_gen = (!ghit_q || glast_q == '0 || glast_q == GEN_MAX) ? GEN_W'(1)
		: glast_q + GEN_W'(1);

	always_comb begin
		live_wr.addr   = addr_q;
		live_wr.kind   = kind_q;
		live_wr.handle = {new_gen, kind_q, next_id_q};
		gen_wr.addr    = addr_q;
		gen_wr.kind    = kind_q;
		gen_wr.last    = new_gen;
		live_we        = state_q == ST_GDEC && slot_ok;
		gen_we         = state_q == ST_GDEC && slot_ok;
	end

	ght_ram #(.WIDTH($bits(live_ent_t)), .DEPTH(TABLE_DEPTH)) u_live_ram (
		.clk   (clk),
		.we    (live_we),
		.waddr (free_idx_q),
		.wdata (live_wr),
		.raddr (lsc_q),
		.rdata (live_rd)
	);

	ght_ram #(.WIDTH($bits(gen_ent_t)), .DEPTH(GEN_DEPTH)) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gslot),
		.wdata (gen_wr),
		.raddr (gsc_q),
		.rdata (gen_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iss_done_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			live_vld_q <= '0;
			gen_vld_q  <= '0;
			next_id_q  <= ID_W'(1);
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
			lsc_q      <= '0;
			gsc_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			ghit_q     <= 1'b0;
			gfree_q    <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			rd_last_s1 <= last_issue;
			lidx_s1    <= lsc_q;
			gidx_s1    <= gsc_q;
			if (issue) begin
				if (last_issue) begin
					iss_done_q <= 1'b1;
				end else if (state_q == ST_LSCAN) begin
					lsc_q <= lsc_q + TW'(1);
				end else begin
					gsc_q <= gsc_q + GW'(1);
				end
			end
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						act_q      <= s_tdata[2:0];
						addr_q     <= s_tdata[66:3];
						kind_q     <= s_tdata[74:67];
						hin_q      <= s_tdata[138:75];
						lsc_q      <= '0;
						iss_done_q <= 1'b0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						res_h_q    <= '0;
						res_a_q    <= '0;
						res_k_q    <= '0;
						res_ok_q   <= 1'b0;
						state_q    <= ST_LSCAN;
					end
				end
				ST_LSCAN: begin
					if (rd_vld_s1) begin
						if (live_vld_q[lidx_s1] && key_hit && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= lidx_s1;
							hit_ent_q <= live_rd;
						end
						if (!live_vld_q[lidx_s1] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= lidx_s1;
						end
						if (rd_last_s1) begin
							state_q <= ST_LDEC;
						end
					end
				end
				ST_LDEC: begin
					state_q <= ST_DONE;
					case (act_q)
						ACT_REGISTER: begin
							if (addr_q != '0 && kind_q != '0) begin
								if (hit_q) begin
									res_h_q  <= hit_ent_q.handle;
									res_ok_q <= 1'b1;
								end else if (free_q) begin
									gsc_q      <= '0;
									iss_done_q <= 1'b0;
									ghit_q     <= 1'b0;
									gfree_q    <= 1'b0;
									state_q    <= ST_GSCAN;
								end
							end
						end
						ACT_INV_ADDR, ACT_INV_HANDLE: begin
							if (hit_q && ((act_q == ACT_INV_ADDR) ? addr_q != '0
								: hin_q != '0)) begin
								live_vld_q[hit_idx_q] <= 1'b0;
								total_q  <= total_q - CNT_W'(1);
								res_ok_q <= 1'b1;
							end
						end
						ACT_RESOLVE: begin
							if (hin_q != '0 && hit_q && hin_q[ID_W-1:0] != '0 &&
								hin_q[ID_W +: KIND_W] == hit_ent_q.kind) begin
								res_k_q <= hit_ent_q.kind;
								if (kind_q == '0 || kind_q == hit_ent_q.kind) begin
									res_a_q  <= hit_ent_q.addr;
									res_ok_q <= 1'b1;
								end
							end
						end
						ACT_CLEAR: begin
							live_vld_q <= '0;
							gen_vld_q  <= '0;
							total_q    <= '0;
							res_ok_q   <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				ST_GSCAN: begin
					if (rd_vld_s1) begin
						if (gen_vld_q[gidx_s1] && gen_key_hit && !ghit_q) begin
							ghit_q     <= 1'b1;
							ghit_idx_q <= gidx_s1;
							glast_q    <= gen_rd.last;
						end
						if (!gen_vld_q[gidx_s1] && !gfree_q) begin
							gfree_q     <= 1'b1;
							gfree_idx_q <= gidx_s1;
						end
						if (rd_last_s1) begin
							state_q <= ST_GDEC;
						end
					end
				end
				ST_GDEC: begin
					// The id is consumed even when it turns out to be zero.
					if (ghit_q || gfree_q) begin
						next_id_q <= next_id_q + ID_W'(1);
					end
					if (slot_ok) begin
						gen_vld_q[gslot]       <= 1'b1;
						live_vld_q[free_idx_q] <= 1'b1;
						total_q  <= total_q + CNT_W'(1);
						res_h_q  <= live_wr.handle;
						res_ok_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			o_h_q   <= res_h_q;
			o_a_q   <= res_a_q;
			o_k_q   <= res_k_q;
			o_ok_q  <= res_ok_q;
			o_cnt_q <= total_q;
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({o_cnt_q, o_k_q, o_a_q, o_ok_q, o_h_q});

`ifndef SYNTHESIS
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live_vld_q) == int'(total_q))
		else $error("live count differs from the number of valid entries");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(total_q) <= TABLE_DEPTH)
		else $error("live count exceeds table depth");

	a_handle_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && o_h_q != '0 |-> o_ok_q)
		else $error("nonzero handle reported without success");
`endif

endmodule
